/* sv/tsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-shift blur blend package
// Shared sizes, register codes, tanh table, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int TANH_TABLE_SIZE = 256;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int DIM_W     = 11;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BAND_HEIGHT  = 3'd2,
    REG_FOCUS_ROW    = 3'd3,
    REG_DECAY_RATE   = 3'd4
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;
  localparam logic [CFG_W-1:0] RESET_BAND   = 14'd1536;
  localparam logic [CFG_W-1:0] RESET_FOCUS  = 14'd3840;
  localparam logic [CFG_W-1:0] RESET_DECAY  = 14'd77;

  // tanh lookup: index over |x| in steps of 8/TANH_TABLE_SIZE
  localparam int TANH_IDX_W     = $clog2(TANH_TABLE_SIZE);
  localparam int TANH_SPAN_LOG2 = 3;
  localparam int TANH_Q_W       = TANH_IDX_W + 16;
  localparam int TANH_SHIFT     = TANH_Q_W - TANH_SPAN_LOG2;
  localparam int MAG_W          = 16;
  localparam int DIV_D_W        = 15;
  localparam int DIV_NUM_W      = MAG_W + TANH_SHIFT;
  localparam int DIV_CNT_W      = $clog2(DIV_NUM_W);

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // blur = floor((sum*111 + 500)/1000); /1000 by reciprocal multiply
  localparam int BLUR_MUL    = 111;
  localparam int BLUR_BIAS   = 500;
  localparam int RECIP_M     = 268436;
  localparam int RECIP_SHIFT = 28;

  typedef logic [16:0] tanh_table_t [TANH_TABLE_SIZE];

  // shift-and-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_table_t build_tanh_table();
    tanh_table_t     tbl;
    longint unsigned h, h2, p3, p5, p7, p9, s, t, v;
    h  = (64'd1 << 33) / TANH_TABLE_SIZE;
    h2 = (h * h) >> 30;
    p3 = (h * h2) >> 30;
    p5 = (p3 * h2) >> 30;
    p7 = (p5 * h2) >> 30;
    p9 = (p7 * h2) >> 30;
    s  = h + udiv64(2 * p5, 64'd15) + udiv64(62 * p9, 64'd2835)
           - udiv64(p3, 64'd3) - udiv64(17 * p7, 64'd315);
    t  = 0;
    for (int k = 0; k < TANH_TABLE_SIZE; k++) begin
      v = (t + 64'd8192) >> 14;
      tbl[k] = (v > 64'd65536) ? ONE_Q16 : v[16:0];
      t = udiv64((t + s) << 30, (64'd1 << 30) + ((t * s) >> 30));
    end
    return tbl;
  endfunction

  localparam tanh_table_t TANH_TABLE = build_tanh_table();

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       alpha_start;
    logic       alpha_sel;
    logic       alpha_wait;
    logic       emit_sum;
    logic       emit_scale;
    logic       emit_recip;
    logic       emit_push;
    logic [1:0] emit_sel;
    logic       emit_last;
  } tsb_cmd_t;

  typedef struct packed {
    logic r_ge1;
    logic c_ge1;
    logic c_end;
    logic r_last;
    logic alpha_done;
    logic out_free;
  } tsb_status_t;

endpackage

/* sv/tsb_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-shift stream interfaces
// Pixel request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       start_of_frame;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, start_of_frame,
                  input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, start_of_frame,
                  output ready);
endinterface

interface tsb_result_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               out_red;
  logic [7:0]               out_green;
  logic [7:0]               out_blue;
  logic [tsb_pkg::ROW_W-1:0] out_row;
  logic [tsb_pkg::COL_W-1:0] out_column;
  logic                     last_of_run;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_column,
                  last_of_run, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_row, out_column,
                  last_of_run, output ready);
endinterface

/* sv/tsb_alpha.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-shift row weight unit
// Iterative tanh difference for one row: up to two restoring divisions, table
// lookup with linear interpolation, then the halved, floored difference, clamped at zero.
// ----------------------------------------------------------------------------
module tsb_alpha (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tsb_pkg::ROW_W-1:0]  row,
  input  logic [tsb_pkg::CFG_W-1:0]  band,
  input  logic [tsb_pkg::CFG_W-1:0]  focus,
  input  logic [tsb_pkg::CFG_W-1:0]  decay,
  output logic                       done,
  output logic [16:0]                alpha
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_SETUP,
    A_DIV,
    A_LOOK,
    A_INTERP,
    A_FINISH
  } state_t;

  state_t                              state;
  logic                                term;
  logic [tsb_pkg::ROW_W-1:0]           row_q;
  logic                                neg;
  logic [tsb_pkg::DIV_NUM_W-1:0]       num;
  logic [tsb_pkg::DIV_D_W-1:0]         rem;
  logic [tsb_pkg::TANH_Q_W-1:0]        quo;
  logic [tsb_pkg::DIV_CNT_W-1:0]       cnt;
  logic [16:0]                         t0_q;
  logic [32:0]                         prod_q;
  logic signed [17:0]                  tanh_p;
  logic signed [17:0]                  tanh_m;

  logic [tsb_pkg::DIV_D_W-1:0]         d;
  logic signed [18:0]                  base;
  logic signed [18:0]                  n;
  logic [18:0]                         n_abs;
  logic [tsb_pkg::MAG_W-1:0]           mag;
  logic                                sat;
  logic [tsb_pkg::DIV_D_W:0]           rem2;
  logic                                qbit;
  logic [tsb_pkg::TANH_IDX_W-1:0]      idx;
  logic [15:0]                         fr;
  logic [16:0]                         t0;
  logic [16:0]                         t1;
  logic [16:0]                         v_interp;
  logic [33:0]                         rounded;
  logic signed [18:0]                  diff;

  always_comb begin
    d     = (decay == '0) ? 15'd2 : {decay, 1'b0};
    base  = $signed({4'b0, row_q, 5'b0}) - $signed({4'b0, focus, 1'b0});
    n     = term ? base - $signed({5'b0, band}) : base + $signed({5'b0, band});
    n_abs = n[18] ? 19'(-n) : 19'(n);
    mag   = n_abs[tsb_pkg::MAG_W-1:0];
    sat   = {2'b0, mag} >= {d, 3'b0};
    rem2  = {rem, num[tsb_pkg::DIV_NUM_W-1]};
    qbit  = rem2 >= {1'b0, d};
    idx   = quo[tsb_pkg::TANH_Q_W-1:16];
    fr    = quo[15:0];
    t0    = tsb_pkg::TANH_TABLE[idx];
    t1    = (idx == {tsb_pkg::TANH_IDX_W{1'b1}}) ? tsb_pkg::ONE_Q16
                                                   : tsb_pkg::TANH_TABLE[idx + 1'b1];
    rounded  = {1'b0, prod_q} + 34'd32768;
    v_interp = t0_q + rounded[32:16];
    diff     = {tanh_p[17], tanh_p} - {tanh_m[17], tanh_m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      term  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (start) begin
            row_q <= row;
            term  <= 1'b0;
            state <= A_SETUP;
          end
        end
        A_SETUP: begin
          neg <= n[18];
          num <= {mag, {tsb_pkg::TANH_SHIFT{1'b0}}};
          rem <= '0;
          quo <= '0;
          cnt <= tsb_pkg::DIV_CNT_W'(tsb_pkg::DIV_NUM_W - 1);
          if (sat) begin
            if (term) begin
              tanh_m <= n[18] ? -$signed({1'b0, tsb_pkg::ONE_Q16})
                              : $signed({1'b0, tsb_pkg::ONE_Q16});
              state  <= A_FINISH;
            end else begin
              tanh_p <= n[18] ? -$signed({1'b0, tsb_pkg::ONE_Q16})
                              : $signed({1'b0, tsb_pkg::ONE_Q16});
              term   <= 1'b1;
            end
          end else begin
            state <= A_DIV;
          end
        end
        A_DIV: begin
          num <= {num[tsb_pkg::DIV_NUM_W-2:0], 1'b0};
          rem <= qbit ? tsb_pkg::DIV_D_W'(rem2 - {1'b0, d})
                      : rem2[tsb_pkg::DIV_D_W-1:0];
          quo <= {quo[tsb_pkg::TANH_Q_W-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= A_LOOK;
        end
        A_LOOK: begin
          t0_q   <= t0;
          prod_q <= 33'(t1 - t0) * 33'(fr);
          state  <= A_INTERP;
        end
        A_INTERP: begin
          if (term) begin
            tanh_m <= neg ? -$signed({1'b0, v_interp}) : $signed({1'b0, v_interp});
            state  <= A_FINISH;
          end else begin
            tanh_p <= neg ? -$signed({1'b0, v_interp}) : $signed({1'b0, v_interp});
            term   <= 1'b1;
            state  <= A_SETUP;
          end
        end
        A_FINISH: begin
          alpha <= diff[18] ? 17'd0 : diff[17:1];
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* sv/tsb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-shift datapath
// Configuration registers, position tracking, line stores, 3x3 window,
// box blur, blend stages and the result output register.
// ----------------------------------------------------------------------------
module tsb_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [tsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsb_pkg::CFG_W-1:0]      cfg_data,
  input  logic [7:0]                     pixel_red,
  input  logic [7:0]                     pixel_green,
  input  logic [7:0]                     pixel_blue,
  input  logic                           start_of_frame,
  input  tsb_pkg::tsb_cmd_t              cmd,
  output tsb_pkg::tsb_status_t           status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [tsb_pkg::ROW_W-1:0]      out_row,
  output logic [tsb_pkg::COL_W-1:0]      out_column,
  output logic                           last_of_run
);

  logic [tsb_pkg::DIM_W-1:0] frame_width;
  logic [tsb_pkg::DIM_W-1:0] frame_height;
  logic [tsb_pkg::CFG_W-1:0] band_height;
  logic [tsb_pkg::CFG_W-1:0] focus_row;
  logic [tsb_pkg::CFG_W-1:0] decay_rate;

  logic [tsb_pkg::ROW_W-1:0] row_count;
  logic [tsb_pkg::COL_W-1:0] column_count;
  logic [tsb_pkg::ROW_W-1:0] cur_r;
  logic [tsb_pkg::COL_W-1:0] cur_c;
  logic [tsb_pkg::PIX_W-1:0] pix;

  logic [tsb_pkg::PIX_W-1:0] above_mem [tsb_pkg::MAX_WIDTH];
  logic [tsb_pkg::PIX_W-1:0] mid_mem   [tsb_pkg::MAX_WIDTH];
  logic [tsb_pkg::PIX_W-1:0] above_rd;
  logic [tsb_pkg::PIX_W-1:0] mid_rd;
  logic [tsb_pkg::PIX_W-1:0] win [3][3];

  logic [16:0]               alpha_a;
  logic [16:0]               alpha_b;
  logic [16:0]               alpha_cur;
  logic [16:0]               alpha_res;
  logic                      alpha_done;

  logic [11:0]               sum_q    [3];
  logic [7:0]                sharp_q  [3];
  logic [17:0]               scaled_q [3];
  logic [7:0]                blur_q   [3];
  logic [tsb_pkg::ROW_W-1:0] row_q;
  logic [tsb_pkg::COL_W-1:0] col_q;

  logic [tsb_pkg::DIM_W-1:0] w;
  logic [tsb_pkg::DIM_W-1:0] h;
  logic [tsb_pkg::DIM_W-1:0] c0, c1, r0, r1, r2;
  logic [tsb_pkg::DIM_W-1:0] cn, rn, rn2;
  logic [1:0]                rs [3];
  logic [1:0]                cs [3];
  logic [11:0]               sum_c [3];
  logic [7:0]                sharp_c [3];
  logic [tsb_pkg::PIX_W-1:0] sharp_pix;
  logic [36:0]               recip [3];
  logic [7:0]                blend [3];
  logic signed [8:0]         dlt [3];
  logic signed [26:0]        bprod [3];
  logic signed [26:0]        btot [3];

  always_comb begin
    w = (frame_width < 11'd3) ? 11'd3 :
        (frame_width > 11'(tsb_pkg::MAX_WIDTH)) ? 11'(tsb_pkg::MAX_WIDTH) : frame_width;
    h = (frame_height < 11'd3) ? 11'd3 :
        (frame_height > 11'(tsb_pkg::MAX_HEIGHT)) ? 11'(tsb_pkg::MAX_HEIGHT) : frame_height;

    c0 = start_of_frame ? '0 : {1'b0, column_count};
    r0 = start_of_frame ? '0 : {1'b0, row_count};
    c1 = (c0 >= w) ? '0 : c0;
    r1 = (c0 >= w) ? r0 + 1'b1 : r0;
    r2 = (r1 >= h) ? '0 : r1;

    cn  = {1'b0, cur_c} + 1'b1;
    rn  = {1'b0, cur_r};
    if (cn >= w) begin
      cn = '0;
      rn = rn + 1'b1;
    end
    rn2 = (rn >= h) ? '0 : rn;

    if (cmd.emit_sel[1]) begin
      rs[0] = 2'd1;
      rs[1] = 2'd2;
      rs[2] = 2'd1;
    end else begin
      rs[0] = (cur_r == 10'd1) ? 2'd2 : 2'd0;
      rs[1] = 2'd1;
      rs[2] = 2'd2;
    end
    if (cmd.emit_sel[0]) begin
      cs[0] = 2'd1;
      cs[1] = 2'd2;
      cs[2] = 2'd1;
    end else begin
      cs[0] = (cur_c == 10'd1) ? 2'd2 : 2'd0;
      cs[1] = 2'd1;
      cs[2] = 2'd2;
    end
    sharp_pix = win[rs[1]][cs[1]];

    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum_c[ch] = sum_c[ch] + 12'(win[rs[i]][cs[j]][23-8*ch -: 8]);
        end
      end
      sharp_c[ch] = sharp_pix[23-8*ch -: 8];
      recip[ch]   = 37'(scaled_q[ch]) * 37'(tsb_pkg::RECIP_M);
      dlt[ch]     = $signed({1'b0, sharp_q[ch]}) - $signed({1'b0, blur_q[ch]});
      bprod[ch]   = 27'($signed({1'b0, alpha_cur}) * dlt[ch]);
      btot[ch]    = $signed({3'b0, blur_q[ch], 16'b0}) + bprod[ch] + 27'sd32768;
      blend[ch]   = btot[ch][23:16];
    end

    status.r_ge1      = cur_r != '0;
    status.c_ge1      = cur_c != '0;
    status.c_end      = {1'b0, cur_c} == w - 1'b1;
    status.r_last     = {1'b0, cur_r} == h - 1'b1;
    status.alpha_done = alpha_done;
    status.out_free   = !out_valid || out_ready;
  end

  tsb_alpha u_alpha (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.alpha_start),
    .row   (cmd.alpha_sel ? cur_r : cur_r - 1'b1),
    .band  (band_height),
    .focus (focus_row),
    .decay (decay_rate),
    .done  (alpha_done),
    .alpha (alpha_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= tsb_pkg::RESET_WIDTH;
      frame_height <= tsb_pkg::RESET_HEIGHT;
      band_height  <= tsb_pkg::RESET_BAND;
      focus_row    <= tsb_pkg::RESET_FOCUS;
      decay_rate   <= tsb_pkg::RESET_DECAY;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        tsb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[tsb_pkg::DIM_W-1:0];
        tsb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[tsb_pkg::DIM_W-1:0];
        tsb_pkg::REG_BAND_HEIGHT:  band_height  <= cfg_data;
        tsb_pkg::REG_FOCUS_ROW:    focus_row    <= cfg_data;
        tsb_pkg::REG_DECAY_RATE:   decay_rate   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (cmd.load) begin
      row_count    <= rn2[tsb_pkg::ROW_W-1:0];
      column_count <= cn[tsb_pkg::COL_W-1:0];
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= above_rd;
      win[1][2] <= mid_rd;
      win[2][2] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r    <= r2[tsb_pkg::ROW_W-1:0];
      cur_c    <= c1[tsb_pkg::COL_W-1:0];
      pix      <= {pixel_red, pixel_green, pixel_blue};
      above_rd <= above_mem[c1[tsb_pkg::COL_W-1:0]];
      mid_rd   <= mid_mem[c1[tsb_pkg::COL_W-1:0]];
    end
    if (cmd.load) begin
      above_mem[cur_c] <= mid_rd;
      mid_mem[cur_c]   <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alpha_wait && alpha_done) begin
      if (cmd.alpha_sel) alpha_b <= alpha_res;
      else               alpha_a <= alpha_res;
    end
    if (cmd.emit_sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch]   <= sum_c[ch];
        sharp_q[ch] <= sharp_c[ch];
      end
      alpha_cur <= cmd.emit_sel[1] ? alpha_b : alpha_a;
      row_q     <= cmd.emit_sel[1] ? cur_r : cur_r - 1'b1;
      col_q     <= cmd.emit_sel[0] ? tsb_pkg::COL_W'(w - 1'b1) : cur_c - 1'b1;
    end
    if (cmd.emit_scale) begin
      for (int ch = 0; ch < 3; ch++) begin
        scaled_q[ch] <= 18'(sum_q[ch]) * 18'(tsb_pkg::BLUR_MUL) + 18'(tsb_pkg::BLUR_BIAS);
      end
    end
    if (cmd.emit_recip) begin
      for (int ch = 0; ch < 3; ch++) begin
        blur_q[ch] <= recip[ch][tsb_pkg::RECIP_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_push) begin
      out_red     <= blend[0];
      out_green   <= blend[1];
      out_blue    <= blend[2];
      out_row     <= row_q;
      out_column  <= col_q;
      last_of_run <= cmd.emit_last;
    end
  end

endmodule

/* sv/tsb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-shift controller
// Sequences one pixel request: capture, window load, row weights, then up to
// four result passes through the blend stages.
// ----------------------------------------------------------------------------
module tsb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output tsb_pkg::tsb_cmd_t    cmd,
  input  tsb_pkg::tsb_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ALPHA_A_GO,
    S_ALPHA_A_WAIT,
    S_ALPHA_B_GO,
    S_ALPHA_B_WAIT,
    S_SUM,
    S_SCALE,
    S_RECIP,
    S_PUSH
  } state_t;

  state_t     state;
  logic [1:0] emit_idx;
  logic [1:0] nxt;
  logic       has_next;

  always_comb begin
    has_next = 1'b0;
    nxt      = emit_idx;
    unique case (emit_idx)
      2'd0: begin
        if (status.c_end) begin
          has_next = 1'b1;
          nxt      = 2'd1;
        end else if (status.r_last) begin
          has_next = 1'b1;
          nxt      = 2'd2;
        end
      end
      2'd1: begin
        has_next = status.r_last;
        nxt      = 2'd2;
      end
      2'd2: begin
        has_next = status.c_end;
        nxt      = 2'd3;
      end
      default: begin
        has_next = 1'b0;
        nxt      = emit_idx;
      end
    endcase

    in_ready        = state == S_IDLE;
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.load        = state == S_LOAD;
    cmd.alpha_start = (state == S_ALPHA_A_GO) || (state == S_ALPHA_B_GO);
    cmd.alpha_sel   = (state == S_ALPHA_B_GO) || (state == S_ALPHA_B_WAIT);
    cmd.alpha_wait  = (state == S_ALPHA_A_WAIT) || (state == S_ALPHA_B_WAIT);
    cmd.emit_sum    = state == S_SUM;
    cmd.emit_scale  = state == S_SCALE;
    cmd.emit_recip  = state == S_RECIP;
    cmd.emit_push   = (state == S_PUSH) && status.out_free;
    cmd.emit_sel    = emit_idx;
    cmd.emit_last   = !has_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      emit_idx <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOAD;
        end
        S_LOAD: begin
          emit_idx <= 2'd0;
          state    <= (status.r_ge1 && status.c_ge1) ? S_ALPHA_A_GO : S_IDLE;
        end
        S_ALPHA_A_GO: state <= S_ALPHA_A_WAIT;
        S_ALPHA_A_WAIT: begin
          if (status.alpha_done) state <= status.r_last ? S_ALPHA_B_GO : S_SUM;
        end
        S_ALPHA_B_GO: state <= S_ALPHA_B_WAIT;
        S_ALPHA_B_WAIT: begin
          if (status.alpha_done) state <= S_SUM;
        end
        S_SUM:   state <= S_SCALE;
        S_SCALE: state <= S_RECIP;
        S_RECIP: state <= S_PUSH;
        S_PUSH: begin
          if (status.out_free) begin
            if (has_next) begin
              emit_idx <= nxt;
              state    <= S_SUM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/tilt_shift_blur_blend.sv */
`timescale 1ns / 1ps
// Pixels in row 0 or column 0 give no result.
// Other pixels compute the row weight (two 37-step divisions, fewer
// when a term saturates), a second weight on the last row, then each result
// through the sum, scale, reciprocal and push states; up to four results.
// A stalled result holds the next push; one pixel in work at a time.
// Synchronous reset: registers to defaults, position and window cleared.
// ----------------------------------------------------------------------------
// Tilt-shift blur blend
// 3x3 box blur of a raster RGB stream blended with the sharp pixel by a
// per-row tanh band weight.
// ----------------------------------------------------------------------------
module tilt_shift_blur_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [tsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsb_pkg::CFG_W-1:0]     cfg_data,
  tsb_pixel_if.sink                     pixels,
  tsb_result_if.source                  results
);

  tsb_pkg::tsb_cmd_t    cmd;
  tsb_pkg::tsb_status_t status;

  tsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .cmd      (cmd),
    .status   (status)
  );

  tsb_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_red      (pixels.pixel_red),
    .pixel_green    (pixels.pixel_green),
    .pixel_blue     (pixels.pixel_blue),
    .start_of_frame (pixels.start_of_frame),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_red        (results.out_red),
    .out_green      (results.out_green),
    .out_blue       (results.out_blue),
    .out_row        (results.out_row),
    .out_column     (results.out_column),
    .last_of_run    (results.last_of_run)
  );

endmodule

/* sv/tsb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-shift port checker
// Port-level properties of the request channels, bound to the top level.
// ----------------------------------------------------------------------------
module tsb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [44:0] out_data
);

  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("new request taken before run of results ended");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind tilt_shift_blur_blend tsb_checker u_tsb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_last  (results.last_of_run),
  .out_data  ({results.out_red, results.out_green, results.out_blue,
               results.out_row, results.out_column, results.last_of_run})
);
